// ===== design/psgrwd_pkg.sv =====
// ----------------------------------------------------------------------------
// psgrwd_pkg: shared types and constants of the PSG register write decoder
// Holds the request codes, field widths and bus byte bit positions.
// ----------------------------------------------------------------------------
`default_nettype none

package psgrwd_pkg;

  localparam int CHAN_W  = 2;
  localparam int VALUE_W = 10;
  localparam int BYTE_W  = 8;
  localparam int VOL_W   = 4;
  localparam int DIV_LO_W = 4;
  localparam int DIV_HI_W = 6;

  // Request codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_WRITE     = 2'd0,
    MODE_DRAIN_DIV = 2'd1,
    MODE_DRAIN_VOL = 2'd2,
    MODE_CLEAR     = 2'd3
  } mode_t;

  // Bus byte layout
  localparam int BIT_COMMAND = 7;   // set: latch or volume byte, clear: data byte
  localparam int BIT_TYPE    = 4;   // set: volume, clear: divider low nibble
  localparam int CH_MSB      = 6;
  localparam int CH_LSB      = 5;

endpackage

`default_nettype wire

// ===== design/psgrwd_if.sv =====
// ----------------------------------------------------------------------------
// psgrwd_if: request and result channels of the PSG register write decoder
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface psgrwd_in_if;
  logic                                valid;
  logic                                ready;
  psgrwd_pkg::mode_t                   mode;
  logic [psgrwd_pkg::BYTE_W-1:0]       write_byte;

  modport source (output valid, output mode, output write_byte, input ready);
  modport sink   (input valid, input mode, input write_byte, output ready);
endinterface

interface psgrwd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                entry_valid;
  logic [psgrwd_pkg::CHAN_W-1:0]       channel;
  logic [psgrwd_pkg::VALUE_W-1:0]      value;
  logic                                is_volume;
  logic                                any_changed;
  logic                                last;

  modport source (output valid, output entry_valid, output channel, output value,
                  output is_volume, output any_changed, output last, input ready);
  modport sink   (input valid, input entry_valid, input channel, input value,
                  input is_volume, input any_changed, input last, output ready);
endinterface

`default_nettype wire

// ===== design/psg_register_write_decoder_core.sv =====
// ----------------------------------------------------------------------------
// psg_register_write_decoder_core: register front end of a four-voice PSG
// Decodes bus bytes into per-channel dividers and volumes with changed flags,
// and drains the changed entries one result word at a time.
// ----------------------------------------------------------------------------
//
//  channel  | dir | word contents                                   | handshake
//  ---------+-----+-------------------------------------------------+-----------
//  in_ch    | in  | mode, write_byte                                | valid/ready
//  out_ch   | out | entry_valid, channel, value, is_volume,         | valid/ready
//           |     | any_changed, last                               |
//
//  A write or clear request is accepted in idle, then applied in the apply
//  state, which also loads the result register. During a drain the
//  sequencer walks one channel flag per cycle, stalling on a changed flag
//  until the result register is free. in_ch.ready is high only while the
//  sequencer idles; a result word waiting in the output register does not
//  block the next request, but a new result stalls until the previous one
//  is taken. Synchronous active-low reset clears all stores and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_register_write_decoder_core #(
  parameter int CHANNEL_COUNT = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  psgrwd_in_if.sink   in_ch,
  psgrwd_out_if.source out_ch
);

  import psgrwd_pkg::*;

  localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W+1)'(CHANNEL_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN
  } state_t;

  state_t                    state_r, state_nxt;
  mode_t                     cmd_mode_r, cmd_mode_nxt;
  logic [BYTE_W-1:0]         cmd_byte_r, cmd_byte_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;

  logic [CHAN_W-1:0]         latched_r, latched_nxt;
  logic [DIV_LO_W-1:0]       div_lo_r [CHANNEL_COUNT];
  logic [DIV_LO_W-1:0]       div_lo_nxt [CHANNEL_COUNT];
  logic [DIV_HI_W-1:0]       div_hi_r [CHANNEL_COUNT];
  logic [DIV_HI_W-1:0]       div_hi_nxt [CHANNEL_COUNT];
  logic [VOL_W-1:0]          vol_r [CHANNEL_COUNT];
  logic [VOL_W-1:0]          vol_nxt [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0]  div_chg_r, div_chg_nxt;
  logic [CHANNEL_COUNT-1:0]  vol_chg_r, vol_chg_nxt;
  logic                      glob_r, glob_nxt;

  // Output register
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_entry_r, out_entry_nxt;
  logic [CHAN_W-1:0]         out_chan_r, out_chan_nxt;
  logic [VALUE_W-1:0]        out_value_r, out_value_nxt;
  logic                      out_isvol_r, out_isvol_nxt;
  logic                      out_any_r, out_any_nxt;
  logic                      out_last_r, out_last_nxt;

  // Scan helpers
  logic                      slot_free;
  logic                      scan_vol;
  logic [CHANNEL_COUNT-1:0]  scan_flags;
  logic [CHANNEL_COUNT-1:0]  pend_mask;
  logic [CHANNEL_COUNT-1:0]  rest_mask;
  logic [CHAN_W-1:0]         byte_ch;

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign scan_vol   = (cmd_mode_r == MODE_DRAIN_VOL);
  assign scan_flags = scan_vol ? vol_chg_r : div_chg_r;
  assign byte_ch    = cmd_byte_r[CH_MSB:CH_LSB];

  // Flags at or above the scan index, and strictly above it
  always_comb begin
    for (int k = 0; k < CHANNEL_COUNT; k++) begin
      pend_mask[k] = scan_flags[k] && (k >= int'(idx_r));
      rest_mask[k] = scan_flags[k] && (k > int'(idx_r));
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_mode_nxt = cmd_mode_r;
    cmd_byte_nxt = cmd_byte_r;
    idx_nxt      = idx_r;
    latched_nxt  = latched_r;
    div_lo_nxt   = div_lo_r;
    div_hi_nxt   = div_hi_r;
    vol_nxt      = vol_r;
    div_chg_nxt  = div_chg_r;
    vol_chg_nxt  = vol_chg_r;
    glob_nxt     = glob_r;

    // Drop the result word once taken
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_entry_nxt = out_entry_r;
    out_chan_nxt  = out_chan_r;
    out_value_nxt = out_value_r;
    out_isvol_nxt = out_isvol_r;
    out_any_nxt   = out_any_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_mode_nxt = in_ch.mode;
          cmd_byte_nxt = in_ch.write_byte;
          idx_nxt      = '0;
          if (in_ch.mode == MODE_DRAIN_DIV || in_ch.mode == MODE_DRAIN_VOL) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end

      ST_APPLY: begin
        // Hold the update until the result register can take its word
        if (slot_free) begin
          if (cmd_mode_r == MODE_CLEAR) begin
            glob_nxt = 1'b0;
          end else if (cmd_byte_r[BIT_COMMAND]) begin
            if (!cmd_byte_r[BIT_TYPE]) begin
              latched_nxt = byte_ch;
              if ({1'b0, byte_ch} < CH_LIMIT) begin
                div_lo_nxt[byte_ch[IDX_W-1:0]]  = cmd_byte_r[DIV_LO_W-1:0];
                div_chg_nxt[byte_ch[IDX_W-1:0]] = 1'b0;
              end
            end else if ({1'b0, byte_ch} < CH_LIMIT) begin
              vol_nxt[byte_ch[IDX_W-1:0]]     = cmd_byte_r[VOL_W-1:0];
              vol_chg_nxt[byte_ch[IDX_W-1:0]] = 1'b1;
              glob_nxt                        = 1'b1;
            end
          end else if ({1'b0, latched_r} < CH_LIMIT) begin
            div_hi_nxt[latched_r[IDX_W-1:0]]  = cmd_byte_r[DIV_HI_W-1:0];
            div_chg_nxt[latched_r[IDX_W-1:0]] = 1'b1;
            glob_nxt                          = 1'b1;
          end

          out_valid_nxt = 1'b1;
          out_entry_nxt = 1'b0;
          out_chan_nxt  = '0;
          out_value_nxt = '0;
          out_isvol_nxt = 1'b0;
          out_any_nxt   = glob_nxt;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (pend_mask == '0) begin
          // Nothing changed: report an empty word of this drain kind
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_entry_nxt = 1'b0;
            out_chan_nxt  = '0;
            out_value_nxt = '0;
            out_isvol_nxt = scan_vol;
            out_any_nxt   = glob_r;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (scan_flags[idx_r]) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_entry_nxt = 1'b1;
            out_chan_nxt  = CHAN_W'(idx_r);
            out_value_nxt = scan_vol ? VALUE_W'(vol_r[idx_r])
                                     : {div_hi_r[idx_r], div_lo_r[idx_r]};
            out_isvol_nxt = scan_vol;
            out_any_nxt   = glob_r;
            out_last_nxt  = (rest_mask == '0);
            if (scan_vol) begin
              vol_chg_nxt[idx_r] = 1'b0;
            end else begin
              div_chg_nxt[idx_r] = 1'b0;
            end
            if (rest_mask == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else begin
          // Advance past a clean channel
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmd_mode_r  <= MODE_WRITE;
      cmd_byte_r  <= '0;
      idx_r       <= '0;
      latched_r   <= '0;
      for (int k = 0; k < CHANNEL_COUNT; k++) begin
        div_lo_r[k] <= '0;
        div_hi_r[k] <= '0;
        vol_r[k]    <= '0;
      end
      div_chg_r   <= '0;
      vol_chg_r   <= '0;
      glob_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_entry_r <= 1'b0;
      out_chan_r  <= '0;
      out_value_r <= '0;
      out_isvol_r <= 1'b0;
      out_any_r   <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_mode_r  <= cmd_mode_nxt;
      cmd_byte_r  <= cmd_byte_nxt;
      idx_r       <= idx_nxt;
      latched_r   <= latched_nxt;
      div_lo_r    <= div_lo_nxt;
      div_hi_r    <= div_hi_nxt;
      vol_r       <= vol_nxt;
      div_chg_r   <= div_chg_nxt;
      vol_chg_r   <= vol_chg_nxt;
      glob_r      <= glob_nxt;
      out_valid_r <= out_valid_nxt;
      out_entry_r <= out_entry_nxt;
      out_chan_r  <= out_chan_nxt;
      out_value_r <= out_value_nxt;
      out_isvol_r <= out_isvol_nxt;
      out_any_r   <= out_any_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.entry_valid = out_entry_r;
  assign out_ch.channel     = out_chan_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.is_volume   = out_isvol_r;
  assign out_ch.any_changed = out_any_r;
  assign out_ch.last        = out_last_r;

endmodule

`default_nettype wire
